FILE: src/torus_quad_vertex_generator_core_macros.svh
// Assertion macros for the torus quad vertex generator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TORUS_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH
`define TORUS_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TQVG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TQVG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TQVG_ASSERT_IMP(label, ante, cons, msg)
`define TQVG_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: src/tqvg_pkg.sv
// Shared types, constants and functions of the torus quad vertex generator.
// No dependencies.
package tqvg_pkg;

  localparam logic [1:0] CFG_INNER = 2'd0;
  localparam logic [1:0] CFG_OUTER = 2'd1;
  localparam logic [1:0] CFG_SIDES = 2'd2;
  localparam logic [1:0] CFG_RINGS = 2'd3;

  localparam logic [23:0] INNER_RST = 24'd65536;
  localparam logic [23:0] OUTER_RST = 24'd131072;
  localparam logic [12:0] COUNT_RST = 13'd16;
  localparam logic [12:0] MAX_DIV   = 13'd4096;

  localparam logic [1:0] CORNER_P1 = 2'd1;
  localparam logic [2:0] VERT_LAST = 3'd5;
  localparam logic [1:0] CORNER_ORDER [6] = '{2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd1};

  localparam int unsigned DIV_STAGES   = 9;
  localparam int unsigned DIV_STEPS    = 5;
  localparam int unsigned TRIG_STAGES  = 13;
  localparam int unsigned VTX_STAGES   = 3;
  localparam int unsigned PIPE_STAGES  = DIV_STAGES + TRIG_STAGES + VTX_STAGES;
  localparam int unsigned TEX_DELAY    = TRIG_STAGES + VTX_STAGES;
  localparam int unsigned HORNER_STEPS = 5;

  localparam logic [16:0] TEX_ONE  = 17'h10000;
  localparam logic [30:0] TRIG_ONE = 31'h4000_0000;
  localparam logic [29:0] QUARTER_PI = 30'd843314857;
  localparam logic signed [17:0] NORM_MAX = 18'sd65536;

  localparam logic [6:0] SIN_K [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_K [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] SIN_RECIP [5] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_RECIP [5] = '{
    32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)};

  typedef struct packed {
    logic        vld;
    logic [12:0] ring_idx;
    logic [12:0] side_idx;
    logic [1:0]  corner;
    logic        last;
  } tqvg_req_t;

  typedef struct packed {
    logic signed [26:0] pos_x;
    logic signed [26:0] pos_y;
    logic signed [26:0] pos_z;
    logic signed [17:0] norm_x;
    logic signed [17:0] norm_y;
    logic signed [17:0] norm_z;
  } tqvg_geom_t;

  function automatic logic [12:0] clamp_count(input logic [12:0] c);
    if (c == 13'd0) return 13'd1;
    if (c > MAX_DIV) return MAX_DIV;
    return c;
  endfunction

  // round half away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic [63:0] half;
    logic [63:0] mag;
    logic [63:0] res;
    half = 64'd1 << (sh - 1);
    mag  = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    res  = (mag + half) >> sh;
    return v[63] ? $signed(64'd0 - res) : $signed(res);
  endfunction

  // one Horner step: 1 - floor(p / k), with q0 at most one below the quotient
  function automatic logic [30:0] horner_t(input logic [29:0] p, input logic [28:0] q0,
                                           input logic [6:0] k);
    logic [36:0] rr;
    logic [29:0] q;
    rr = 37'(p) - 37'(q0) * 37'(k);
    q  = 30'(q0) + 30'(rr >= 37'(k));
    return TRIG_ONE - 31'(q);
  endfunction

endpackage

FILE: src/tqvg_seq.sv
// Quad sequencer: takes one quad word and issues its six vertex requests.
// Depends on tqvg_pkg.
module tqvg_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic [11:0]        ring_i,
  input  logic [11:0]        side_i,
  output logic               in_ready_o,
  output tqvg_pkg::tqvg_req_t req_o
);

  logic        busy_q, busy_d;
  logic [2:0]  k_q, k_d;
  logic [11:0] ring_q, side_q;
  logic        accept;
  logic [1:0]  corner;

  assign in_ready_o = !busy_q || (k_q == tqvg_pkg::VERT_LAST && en_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (accept) begin
      busy_d = 1'b1;
      k_d    = 3'd0;
    end else if (busy_q && en_i) begin
      if (k_q == tqvg_pkg::VERT_LAST) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= 3'd0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q <= ring_i;
      side_q <= side_i;
    end
  end

  assign corner          = tqvg_pkg::CORNER_ORDER[k_q];
  assign req_o.vld       = busy_q;
  assign req_o.ring_idx  = {1'b0, ring_q} + {12'd0, corner[0]};
  assign req_o.side_idx  = {1'b0, side_q} + {12'd0, corner[1]};
  assign req_o.corner    = corner;
  assign req_o.last      = (k_q == tqvg_pkg::VERT_LAST);

endmodule

FILE: src/tqvg_div.sv
// Pipelined long division of a 45-bit dividend by a 13-bit count.
// Five restoring steps per stage; keeps the low 32 quotient bits. Depends on tqvg_pkg.
module tqvg_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [44:0] num_i,
  input  logic [12:0] den_i,
  output logic [31:0] quo_o
);

  localparam int unsigned NS = tqvg_pkg::DIV_STAGES;

  logic [11:0] rem_in [NS];
  logic [44:0] num_in [NS];
  logic [31:0] quo_in [NS];
  logic [11:0] rem_d  [NS];
  logic [44:0] num_d  [NS];
  logic [31:0] quo_d  [NS];
  logic [11:0] rem_q  [NS];
  logic [44:0] num_q  [NS];
  logic [31:0] quo_q  [NS];

  assign rem_in[0] = 12'd0;
  assign num_in[0] = num_i;
  assign quo_in[0] = 32'd0;

  for (genvar g = 1; g < NS; g++) begin : g_link
    assign rem_in[g] = rem_q[g-1];
    assign num_in[g] = num_q[g-1];
    assign quo_in[g] = quo_q[g-1];
  end

  always_comb begin
    logic [11:0] r;
    logic [44:0] n;
    logic [31:0] q;
    logic [12:0] t;
    for (int j = 0; j < NS; j++) begin
      r = rem_in[j];
      n = num_in[j];
      q = quo_in[j];
      for (int b = 0; b < tqvg_pkg::DIV_STEPS; b++) begin
        t = {r, n[44]};
        n = {n[43:0], 1'b0};
        if (t >= den_i) begin
          r = 12'(t - den_i);
          q = {q[30:0], 1'b1};
        end else begin
          r = t[11:0];
          q = {q[30:0], 1'b0};
        end
      end
      rem_d[j] = r;
      num_d[j] = n;
      quo_d[j] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NS; j++) begin
        rem_q[j] <= rem_d[j];
        num_q[j] <= num_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

FILE: src/tqvg_trig.sv
// Sine and cosine of a 32-bit turn phase in Q30: octant fold, then five
// Horner steps of two stages each. Depends on tqvg_pkg.
module tqvg_trig (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned HS = tqvg_pkg::HORNER_STEPS;

  logic [29:0] r_fold;
  logic [59:0] x_prod, sq_prod;
  logic [2:0]  oct1_q, oct2_q;
  logic [29:0] x1_q, x2x_q, sq_q;

  logic [29:0] ps_in [HS], pc_in [HS], xb_in [HS], x2b_in [HS];
  logic [2:0]  octb_in [HS];
  logic [28:0] q0s_d [HS], q0c_d [HS];
  logic [28:0] q0s_q [HS], q0c_q [HS];
  logic [29:0] ps_q [HS], pc_q [HS], xb_q [HS], x2b_q [HS];
  logic [2:0]  octb_q [HS];
  logic [30:0] ts_d [HS], tc_d [HS];
  logic [29:0] pns_d [HS-1], pnc_d [HS-1];
  logic [29:0] pns_q [HS-1], pnc_q [HS-1], xc_q [HS-1], x2c_q [HS-1];
  logic [2:0]  octc_q [HS];
  logic [60:0] sfin_prod;
  logic [29:0] sfin_q;
  logic [30:0] cfin_q;
  logic signed [31:0] sp, cp, sw, cw;

  assign r_fold  = phase_i[29] ? (30'h2000_0000 - {1'b0, phase_i[28:0]})
                               : {1'b0, phase_i[28:0]};
  assign x_prod  = 60'(r_fold) * 60'(tqvg_pkg::QUARTER_PI);
  assign sq_prod = 60'(x1_q) * 60'(x1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct1_q <= phase_i[31:29];
      x1_q   <= x_prod[58:29];
      oct2_q <= oct1_q;
      x2x_q  <= x1_q;
      sq_q   <= sq_prod[59:30];
    end
  end

  assign ps_in[0]   = sq_q;
  assign pc_in[0]   = sq_q;
  assign xb_in[0]   = x2x_q;
  assign x2b_in[0]  = sq_q;
  assign octb_in[0] = oct2_q;

  for (genvar g = 1; g < HS; g++) begin : g_link
    assign ps_in[g]   = pns_q[g-1];
    assign pc_in[g]   = pnc_q[g-1];
    assign xb_in[g]   = xc_q[g-1];
    assign x2b_in[g]  = x2c_q[g-1];
    assign octb_in[g] = octc_q[g-1];
  end

  always_comb begin
    logic [60:0] ms, mc, ns, nc;
    for (int i = 0; i < HS; i++) begin
      ms       = 61'(ps_in[i]) * 61'(tqvg_pkg::SIN_RECIP[i]);
      mc       = 61'(pc_in[i]) * 61'(tqvg_pkg::COS_RECIP[i]);
      q0s_d[i] = ms[60:32];
      q0c_d[i] = mc[60:32];
      ts_d[i]  = tqvg_pkg::horner_t(ps_q[i], q0s_q[i], tqvg_pkg::SIN_K[i]);
      tc_d[i]  = tqvg_pkg::horner_t(pc_q[i], q0c_q[i], tqvg_pkg::COS_K[i]);
    end
    for (int i = 0; i < HS - 1; i++) begin
      ns       = 61'(x2b_q[i]) * 61'(ts_d[i]);
      nc       = 61'(x2b_q[i]) * 61'(tc_d[i]);
      pns_d[i] = ns[59:30];
      pnc_d[i] = nc[59:30];
    end
  end

  assign sfin_prod = 61'(xb_q[HS-1]) * 61'(ts_d[HS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < HS; i++) begin
        q0s_q[i]  <= q0s_d[i];
        q0c_q[i]  <= q0c_d[i];
        ps_q[i]   <= ps_in[i];
        pc_q[i]   <= pc_in[i];
        xb_q[i]   <= xb_in[i];
        x2b_q[i]  <= x2b_in[i];
        octb_q[i] <= octb_in[i];
        octc_q[i] <= octb_q[i];
      end
      for (int i = 0; i < HS - 1; i++) begin
        pns_q[i] <= pns_d[i];
        pnc_q[i] <= pnc_d[i];
        xc_q[i]  <= xb_q[i];
        x2c_q[i] <= x2b_q[i];
      end
      sfin_q <= sfin_prod[59:30];
      cfin_q <= tc_d[HS-1];
    end
  end

  // octant symmetries: swap on bit0^bit1, sin sign bit2, cos sign bit1^bit2
  assign sp = $signed({2'b00, sfin_q});
  assign cp = $signed({1'b0, cfin_q});
  assign sw = (octc_q[HS-1][0] ^ octc_q[HS-1][1]) ? cp : sp;
  assign cw = (octc_q[HS-1][0] ^ octc_q[HS-1][1]) ? sp : cp;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= octc_q[HS-1][2] ? -sw : sw;
      cos_o <= (octc_q[HS-1][1] ^ octc_q[HS-1][2]) ? -cw : cw;
    end
  end

endmodule

FILE: src/tqvg_vtx.sv
// Vertex position and normal from the two sine/cosine pairs and the radii.
// Three stages: products, ring radius and scaled products, final rounding. Depends on tqvg_pkg.
module tqvg_vtx (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  sa_i,
  input  logic signed [31:0]  ca_i,
  input  logic signed [31:0]  sb_i,
  input  logic signed [31:0]  cb_i,
  input  logic [23:0]         inner_i,
  input  logic [23:0]         outer_i,
  output tqvg_pkg::tqvg_geom_t geom_o
);

  logic signed [24:0] rad_s, dist_s;
  logic signed [56:0] mrc_q, mrs_q;
  logic signed [63:0] mns_q, mnc_q;
  logic signed [31:0] sa1_q, ca1_q, sb1_q;
  logic signed [63:0] reff64;
  logic signed [26:0] reff;
  logic signed [58:0] prs_q, prc_q;
  logic signed [26:0] pz2_q;
  logic signed [17:0] nx2_q, ny2_q, nz2_q;

  assign rad_s  = $signed({1'b0, inner_i});
  assign dist_s = $signed({1'b0, outer_i}) - $signed({1'b0, inner_i});
  assign reff64 = tqvg_pkg::round_shift((64'(dist_s) <<< 30) + 64'(mrc_q), 30);
  assign reff   = 27'(reff64);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mrc_q <= rad_s * cb_i;
      mrs_q <= rad_s * sb_i;
      mns_q <= 64'(cb_i) * 64'(sa_i);
      mnc_q <= 64'(cb_i) * 64'(ca_i);
      sa1_q <= sa_i;
      ca1_q <= ca_i;
      sb1_q <= sb_i;

      prs_q <= reff * sa1_q;
      prc_q <= reff * ca1_q;
      pz2_q <= 27'(tqvg_pkg::round_shift(64'(mrs_q), 30));
      nx2_q <= 18'(tqvg_pkg::round_shift(mns_q, 44));
      ny2_q <= 18'(tqvg_pkg::round_shift(mnc_q, 44));
      nz2_q <= 18'(tqvg_pkg::round_shift(64'(sb1_q), 14));

      geom_o.pos_x  <= 27'(tqvg_pkg::round_shift(64'(prs_q), 30));
      geom_o.pos_y  <= 27'(tqvg_pkg::round_shift(64'(prc_q), 30));
      geom_o.pos_z  <= pz2_q;
      geom_o.norm_x <= nx2_q;
      geom_o.norm_y <= ny2_q;
      geom_o.norm_z <= nz2_q;
    end
  end

endmodule

FILE: src/torus_quad_vertex_generator_core.sv
// Torus quad vertex generator: one quad word in, six vertex words out in the
// corner order p1,p0,p2,p2,p3,p1, the sixth marked by tlast. The pipeline
// takes one vertex per cycle while the output does not stall, and the next
// quad may be presented while earlier vertices are still in flight. Each
// vertex passes through the 45-step division pipeline (9 stages), the Horner
// sine/cosine pipeline (13 stages) and the output multipliers (3 stages). A
// stall on the output freezes the whole pipeline. Depends on tqvg_pkg,
// tqvg_seq, tqvg_div, tqvg_trig, tqvg_vtx and the macros header.
`include "torus_quad_vertex_generator_core_macros.svh"
module torus_quad_vertex_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // ring_index, side_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, zero pad
  output logic [175:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // corner
  output logic         m_axis_tlast
);

  localparam int unsigned NP = tqvg_pkg::PIPE_STAGES;
  localparam int unsigned ND = tqvg_pkg::TEX_DELAY;

  logic [23:0] inner_q, outer_q;
  logic [12:0] sides_q, rings_q, side_cnt, ring_cnt;
  logic        en;
  tqvg_pkg::tqvg_req_t req;
  tqvg_pkg::tqvg_geom_t geom;
  logic [44:0] num_rp, num_sp, num_rt, num_st;
  logic [31:0] ph_r, ph_s, tq_r, tq_s;
  logic signed [31:0] sa, ca, sb, cb;
  logic        vld_q [NP];
  logic [1:0]  corner_q [NP];
  logic        last_q [NP];
  logic [16:0] tu_q [ND], tv_q [ND];
  logic [16:0] tu_sat, tv_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= tqvg_pkg::INNER_RST;
      outer_q <= tqvg_pkg::OUTER_RST;
      sides_q <= tqvg_pkg::COUNT_RST;
      rings_q <= tqvg_pkg::COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tqvg_pkg::CFG_INNER: inner_q <= cfg_data_i;
        tqvg_pkg::CFG_OUTER: outer_q <= cfg_data_i;
        tqvg_pkg::CFG_SIDES: sides_q <= cfg_data_i[12:0];
        tqvg_pkg::CFG_RINGS: rings_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign side_cnt = tqvg_pkg::clamp_count(sides_q);
  assign ring_cnt = tqvg_pkg::clamp_count(rings_q);
  assign en       = !vld_q[NP-1] || m_axis_tready;

  tqvg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .ring_i     (s_axis_tdata[11:0]),
    .side_i     (s_axis_tdata[23:12]),
    .in_ready_o (s_axis_tready),
    .req_o      (req)
  );

  // phase: idx * 2^32 + count/2, texture: idx * 2^16 + count/2
  assign num_rp = {req.ring_idx, 20'd0, ring_cnt[12:1]};
  assign num_sp = {req.side_idx, 20'd0, side_cnt[12:1]};
  assign num_rt = {16'd0, req.ring_idx, 4'd0, ring_cnt[12:1]};
  assign num_st = {16'd0, req.side_idx, 4'd0, side_cnt[12:1]};

  tqvg_div u_div_rp (.clk_i(clk_i), .en_i(en), .num_i(num_rp), .den_i(ring_cnt), .quo_o(ph_r));
  tqvg_div u_div_sp (.clk_i(clk_i), .en_i(en), .num_i(num_sp), .den_i(side_cnt), .quo_o(ph_s));
  tqvg_div u_div_rt (.clk_i(clk_i), .en_i(en), .num_i(num_rt), .den_i(ring_cnt), .quo_o(tq_r));
  tqvg_div u_div_st (.clk_i(clk_i), .en_i(en), .num_i(num_st), .den_i(side_cnt), .quo_o(tq_s));

  tqvg_trig u_trig_a (.clk_i(clk_i), .en_i(en), .phase_i(ph_r), .sin_o(sa), .cos_o(ca));
  tqvg_trig u_trig_b (.clk_i(clk_i), .en_i(en), .phase_i(ph_s), .sin_o(sb), .cos_o(cb));

  tqvg_vtx u_vtx (
    .clk_i   (clk_i),
    .en_i    (en),
    .sa_i    (sa),
    .ca_i    (ca),
    .sb_i    (sb),
    .cb_i    (cb),
    .inner_i (inner_q),
    .outer_i (outer_q),
    .geom_o  (geom)
  );

  assign tu_sat = (tq_s > 32'(tqvg_pkg::TEX_ONE)) ? tqvg_pkg::TEX_ONE : tq_s[16:0];
  assign tv_sat = (tq_r > 32'(tqvg_pkg::TEX_ONE)) ? tqvg_pkg::TEX_ONE : tq_r[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= req.vld;
      for (int i = 1; i < NP; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      corner_q[0] <= req.corner;
      last_q[0]   <= req.last;
      for (int i = 1; i < NP; i++) begin
        corner_q[i] <= corner_q[i-1];
        last_q[i]   <= last_q[i-1];
      end
      tu_q[0] <= tu_sat;
      tv_q[0] <= tv_sat;
      for (int i = 1; i < ND; i++) begin
        tu_q[i] <= tu_q[i-1];
        tv_q[i] <= tv_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NP-1];
  assign m_axis_tuser  = corner_q[NP-1];
  assign m_axis_tlast  = last_q[NP-1];
  assign m_axis_tdata  = {7'd0, tv_q[ND-1], tu_q[ND-1], geom.norm_z, geom.norm_y,
                          geom.norm_x, geom.pos_z, geom.pos_y, geom.pos_x};

  `TQVG_ASSERT_IMP(a_last_is_p1, m_axis_tvalid && m_axis_tlast, m_axis_tuser == tqvg_pkg::CORNER_P1, "last vertex is not corner p1")
  `TQVG_ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, req.vld && req.corner == tqvg_pkg::CORNER_P1, "quad accept did not start at corner p1")
  `TQVG_ASSERT_IMP(a_norm_range, m_axis_tvalid, ($signed(geom.norm_z) <= tqvg_pkg::NORM_MAX) && ($signed(geom.norm_z) >= -tqvg_pkg::NORM_MAX), "normal z out of unit range")

endmodule

FILE: dv/torus_quad_vertex_generator_core_tb.sv
// Self-checking testbench for torus_quad_vertex_generator_core: drives quad
// words, predicts the six vertex words of each quad, and checks every output word.
// Depends on tqvg_pkg and the core RTL.
`timescale 1ns / 1ps
module torus_quad_vertex_generator_core_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam longint unsigned Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [26:0] pos_x;
    logic [26:0] pos_y;
    logic [26:0] pos_z;
    logic [17:0] norm_x;
    logic [17:0] norm_y;
    logic [17:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  corner;
    logic        last;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = tqvg_pkg::CFG_INNER;
  logic [23:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;  // ring_index, side_index
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;       // pos_x..pos_z, norm_x..norm_z, tex_u, tex_v, pad
  logic [1:0]   m_axis_tuser;       // corner
  logic         m_axis_tlast;

  torus_quad_vertex_generator_core u_top (.*);

  longint unsigned inner_r = tqvg_pkg::INNER_RST, outer_r = tqvg_pkg::OUTER_RST;
  longint unsigned sides_raw = tqvg_pkg::COUNT_RST, rings_raw = tqvg_pkg::COUNT_RST;
  vertex_t expected_vertices[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned src_idle = 0, snk_idle = 0, hold_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sink: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // output words are sampled mid-cycle, accepted at the next rising edge
  always @(negedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[26:0], m_axis_tdata[53:27], m_axis_tdata[80:54],
             m_axis_tdata[98:81], m_axis_tdata[116:99], m_axis_tdata[134:117],
             m_axis_tdata[151:135], m_axis_tdata[168:152], m_axis_tuser, m_axis_tlast};
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_vertices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp pos %h %h %h nrm %h %h %h tex %h %h c %0d l %0b\n",
                     want.pos_x, want.pos_y, want.pos_z, want.norm_x, want.norm_y,
                     want.norm_z, want.tex_u, want.tex_v, want.corner, want.last,
                     "         got pos %h %h %h nrm %h %h %h tex %h %h c %0d l %0b",
                     got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y,
                     got.norm_z, got.tex_u, got.tex_v, got.corner, got.last);
        end
      end
    end
  end

  function automatic longint round_sh(longint v, int sh);
    longint unsigned half, mag;
    half = 64'd1 << (sh - 1);
    if (v < 0) begin
      mag = -v;
      return -longint'((mag + half) >> sh);
    end
    return longint'((longint'(v) + half) >> sh);
  endfunction

  function automatic longint unsigned clamp_div(longint unsigned c);
    if (c == 0) return 1;
    if (c > 4096) return 4096;
    return c;
  endfunction

  function automatic void sin_cos_q30(logic [31:0] ph, output longint sn, output longint cs);
    longint unsigned ks[5] = '{110, 72, 42, 20, 6};
    longint unsigned kc[5] = '{90, 56, 30, 12, 2};
    longint unsigned r, x, x2, ts, tc;
    longint s, c;
    logic [2:0] oct;
    oct = ph[31:29];
    r = ph[28:0];
    if (oct[0]) r = 64'h2000_0000 - r;
    x = (r * 64'd843314857) >> 29;
    x2 = (x * x) >> 30;
    ts = Q30;
    tc = Q30;
    for (int i = 0; i < 5; i++) begin
      ts = Q30 - ((x2 * ts) >> 30) / ks[i];
      tc = Q30 - ((x2 * tc) >> 30) / kc[i];
    end
    s = longint'((x * ts) >> 30);
    c = longint'(tc);
    case (oct)
      3'd0: begin sn = s;  cs = c;  end
      3'd1: begin sn = c;  cs = s;  end
      3'd2: begin sn = c;  cs = -s; end
      3'd3: begin sn = s;  cs = -c; end
      3'd4: begin sn = -s; cs = -c; end
      3'd5: begin sn = -c; cs = -s; end
      3'd6: begin sn = -c; cs = s;  end
      default: begin sn = -s; cs = c; end
    endcase
  endfunction

  function automatic logic [31:0] turn_phase(longint unsigned idx, longint unsigned cnt);
    return 32'((((idx % cnt) << 32) + cnt / 2) / cnt);
  endfunction

  function automatic logic [16:0] tex_of(longint unsigned idx, longint unsigned cnt);
    longint unsigned t;
    t = ((idx << 16) + cnt / 2) / cnt;
    return (t > 65536) ? 17'h10000 : 17'(t);
  endfunction

  function automatic vertex_t torus_vertex(longint unsigned ring, longint unsigned side,
                                           logic [1:0] corner, logic last);
    longint unsigned rc, sc, ri, si;
    longint sa, ca, sb, cb, ring_dist, reff;
    vertex_t v;
    rc = clamp_div(rings_raw);
    sc = clamp_div(sides_raw);
    ri = ring + corner[0];
    si = side + corner[1];
    sin_cos_q30(turn_phase(ri, rc), sa, ca);
    sin_cos_q30(turn_phase(si, sc), sb, cb);
    ring_dist = longint'(outer_r) - longint'(inner_r);
    reff = round_sh(ring_dist * longint'(Q30) + longint'(inner_r) * cb, 30);
    v.pos_x = 27'(round_sh(reff * sa, 30));
    v.pos_y = 27'(round_sh(reff * ca, 30));
    v.pos_z = 27'(round_sh(longint'(inner_r) * sb, 30));
    v.norm_x = 18'(round_sh(cb * sa, 44));
    v.norm_y = 18'(round_sh(cb * ca, 44));
    v.norm_z = 18'(round_sh(sb, 14));
    v.tex_u = tex_of(si, sc);
    v.tex_v = tex_of(ri, rc);
    v.corner = corner;
    v.last = last;
    return v;
  endfunction

  task automatic send_quad(logic [11:0] ring, logic [11:0] side);
    logic [1:0] order[6] = '{2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd1};
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {side, ring};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    for (int k = 0; k < 6; k++)
      expected_vertices = {expected_vertices, torus_vertex(ring, side, order[k], k == 5)};
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tqvg_pkg::CFG_INNER: inner_r = val;
      tqvg_pkg::CFG_OUTER: outer_r = val;
      tqvg_pkg::CFG_SIDES: sides_raw = val[12:0];
      default:             rings_raw = val[12:0];
    endcase
  endtask

  task automatic set_shape(logic [23:0] inner, logic [23:0] outer,
                           logic [12:0] sides, logic [12:0] rings);
    write_reg(tqvg_pkg::CFG_INNER, inner);
    write_reg(tqvg_pkg::CFG_OUTER, outer);
    write_reg(tqvg_pkg::CFG_SIDES, sides);
    write_reg(tqvg_pkg::CFG_RINGS, rings);
  endtask

  task automatic test_index_edges();
    send_quad(12'd0, 12'd0);
    send_quad(12'd15, 12'd15);
    send_quad(12'd16, 12'd0);
    send_quad(12'd0, 12'd16);
    send_quad(12'd4095, 12'd4095);
    send_quad(12'hAAA, 12'h555);
    send_quad(12'h555, 12'hAAA);
    send_quad(12'd3, 12'd7);
  endtask

  task automatic test_shape_extremes();
    set_shape(24'd0, 24'd196608, 13'd16, 13'd16);      // zero tube radius
    send_quad(12'd1, 12'd2);
    send_quad(12'd6, 12'd11);
    set_shape(24'hFFFFFF, 24'd0, 13'd1, 13'd1);         // inner above outer
    send_quad(12'd0, 12'd0);
    send_quad(12'd4095, 12'd1);
    set_shape(24'hFFFFFF, 24'hFFFFFF, 13'd4096, 13'd4096);
    send_quad(12'd4095, 12'd2047);
    send_quad(12'd1024, 12'd3072);
    set_shape(24'd32768, 24'hFFFFFF, 13'd0, 13'd8191); // counts clamp
    send_quad(12'd0, 12'd4095);
    send_quad(12'd4095, 12'd0);
    set_shape(24'd70000, 24'd300000, 13'd3, 13'd5);
    send_quad(12'd2, 12'd4);
    send_quad(12'd9, 12'd1);
  endtask

  task automatic random_quads(int unsigned n);
    longint unsigned sc, rc;
    sc = clamp_div(sides_raw);
    rc = clamp_div(rings_raw);
    repeat (n) begin
      if ($urandom_range(9) < 7)
        send_quad(12'($urandom_range(rc > 4095 ? 4095 : rc)),
                  12'($urandom_range(sc > 4095 ? 4095 : sc)));
      else
        send_quad(12'($urandom), 12'($urandom));
    end
  endtask

  task automatic random_shape();
    logic [12:0] s, r;
    s = ($urandom_range(9) == 0) ? 13'd4096 : 13'($urandom_range(64, 1));
    r = ($urandom_range(9) == 0) ? 13'd4096 : 13'($urandom_range(64, 1));
    set_shape(24'($urandom_range(24'hFFFFFF)), 24'($urandom), s, r);
  endtask

  task automatic test_random_traffic();
    random_shape();
    src_idle = 30; snk_idle = 82;
    random_quads(100);
    random_shape();
    src_idle = 82; snk_idle = 30;
    random_quads(100);
    random_shape();
    src_idle = 0; snk_idle = 0;
    random_quads(100);
  endtask

  task automatic test_output_backpressure();
    src_idle = 0; snk_idle = 0;
    hold_cycles = 400;
    random_quads(12);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_index_edges();
    test_shape_extremes();
    test_random_traffic();
    test_output_backpressure();
    drain();
    if (mismatches == 0 && expected_vertices.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
